FILE: src/dmsc_pkg.sv
// ----------------------------------------------------------------------------
// dmsc_pkg: shared types and constants of the Bayer demosaic block
// Pixel and dimension widths, register indexes, reset values and the
// structs that travel between the position counter, line memory and
// interpolation window.
// ----------------------------------------------------------------------------
package dmsc_pkg;

  localparam int unsigned PIX_W         = 8;
  localparam int unsigned DIM_W         = 13;
  localparam int unsigned MAX_WIDTH_DEF = 4096;
  localparam int unsigned HEIGHT_LIMIT  = 4096;
  localparam int unsigned MIN_DIM       = 2;
  localparam int unsigned APB_DATA_W    = 32;
  localparam int unsigned APB_ADDR_W    = 3;

  localparam logic [DIM_W-1:0] RESET_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0] RESET_HEIGHT = 13'd480;

  // Register index, taken from paddr[2]
  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  typedef logic [PIX_W-1:0] pix_t;

  // One window column: upper row, middle row, current row
  typedef struct packed {
    pix_t upper;
    pix_t middle;
    pix_t lower;
  } column_t;

  // One line memory word: both line stores at one column
  typedef struct packed {
    pix_t upper;
    pix_t middle;
  } line_word_t;

  // Emit control for one request
  typedef struct packed {
    logic emit;       // request produces a pixel
    logic top;        // pixel sits in the first image row
    logic bottom;     // pixel sits in the last image row
    logic y_odd;      // pixel row is a G/B row
    logic x_odd;      // pixel column is odd
    logic x_first;    // pixel is in column 0
    logic row_end;    // pixel is the last of its row
    logic frame_end;  // pixel is the last of the frame
  } pos_info_t;

endpackage

FILE: src/dmsc_stream_if.sv
// ----------------------------------------------------------------------------
// dmsc stream interfaces
// Valid/ready channels for raw Bayer samples in and RGB pixels out.
// ----------------------------------------------------------------------------
interface dmsc_in_if;
  logic                 valid;
  logic                 ready;
  dmsc_pkg::pix_t       raw_pixel;
  logic                 drain;

  modport source (output valid, output raw_pixel, output drain, input ready);
  modport sink   (input valid, input raw_pixel, input drain, output ready);
endinterface

interface dmsc_out_if;
  logic                 valid;
  logic                 ready;
  dmsc_pkg::pix_t       red;
  dmsc_pkg::pix_t       green;
  dmsc_pkg::pix_t       blue;
  logic                 row_end;
  logic                 frame_end;

  modport source (output valid, output red, output green, output blue,
                  output row_end, output frame_end, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input row_end, input frame_end, output ready);
endinterface

FILE: src/dmsc_cfg.sv
// ----------------------------------------------------------------------------
// dmsc_cfg: APB register file
// Holds frame width and height and presents them clamped to the legal
// range for the datapath.
// ----------------------------------------------------------------------------
module dmsc_cfg #(
  parameter int unsigned MAX_WIDTH = dmsc_pkg::MAX_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dmsc_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [dmsc_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [dmsc_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output logic [$clog2(MAX_WIDTH):0]          w_eff,
  output logic [dmsc_pkg::DIM_W-1:0]          h_eff
);

  localparam int unsigned WW   = $clog2(MAX_WIDTH) + 1;
  localparam int unsigned DW   = dmsc_pkg::DIM_W;
  localparam int unsigned CMPW = (WW > DW) ? WW : DW;

  logic [DW-1:0]       fw_r, fw_nxt;
  logic [DW-1:0]       fh_r, fh_nxt;
  logic                wr_en;
  dmsc_pkg::reg_idx_t  idx;
  logic [CMPW-1:0]     fw_ext;
  logic [CMPW-1:0]     fw_clamp;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = dmsc_pkg::reg_idx_t'(paddr[2]);

  // Decode register writes
  always_comb begin
    fw_nxt = fw_r;
    fh_nxt = fh_r;
    if (wr_en) begin
      case (idx)
        dmsc_pkg::REG_FRAME_WIDTH:  fw_nxt = pwdata[DW-1:0];
        dmsc_pkg::REG_FRAME_HEIGHT: fh_nxt = pwdata[DW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= dmsc_pkg::RESET_WIDTH;
      fh_r <= dmsc_pkg::RESET_HEIGHT;
    end else begin
      fw_r <= fw_nxt;
      fh_r <= fh_nxt;
    end
  end

  // Read back raw register values
  always_comb begin
    case (idx)
      dmsc_pkg::REG_FRAME_WIDTH:  prdata = dmsc_pkg::APB_DATA_W'(fw_r);
      dmsc_pkg::REG_FRAME_HEIGHT: prdata = dmsc_pkg::APB_DATA_W'(fh_r);
      default:                    prdata = '0;
    endcase
  end

  // Clamp width to [2, MAX_WIDTH]
  always_comb begin
    fw_ext = CMPW'(fw_r);
    if (fw_ext < CMPW'(dmsc_pkg::MIN_DIM)) begin
      fw_clamp = CMPW'(dmsc_pkg::MIN_DIM);
    end else if (fw_ext > CMPW'(MAX_WIDTH)) begin
      fw_clamp = CMPW'(MAX_WIDTH);
    end else begin
      fw_clamp = fw_ext;
    end
    w_eff = fw_clamp[WW-1:0];
  end

  // Clamp height to [2, HEIGHT_LIMIT]
  always_comb begin
    if (fh_r < DW'(dmsc_pkg::MIN_DIM)) begin
      h_eff = DW'(dmsc_pkg::MIN_DIM);
    end else if (fh_r > DW'(dmsc_pkg::HEIGHT_LIMIT)) begin
      h_eff = DW'(dmsc_pkg::HEIGHT_LIMIT);
    end else begin
      h_eff = fh_r;
    end
  end

endmodule

FILE: src/dmsc_line_mem.sv
// ----------------------------------------------------------------------------
// dmsc_line_mem: line store memory
// One word per column holding the upper and middle lines. Synchronous
// read with registered data, one write port; a read and a write to the
// same address in one cycle return the old word.
// ----------------------------------------------------------------------------
module dmsc_line_mem #(
  parameter int unsigned MAX_WIDTH = dmsc_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
  output dmsc_pkg::line_word_t          rd_data,
  input  logic                          wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]  wr_addr,
  input  dmsc_pkg::line_word_t          wr_data
);

  dmsc_pkg::line_word_t mem [MAX_WIDTH];
  dmsc_pkg::line_word_t rd_data_r;

  // Write back the shifted column
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read and hold until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/dmsc_pos.sv
// ----------------------------------------------------------------------------
// dmsc_pos: stream position counter
// Tracks row and column of the next sample, wraps at the frame edges and
// derives what pixel, if any, the current request emits.
// ----------------------------------------------------------------------------
module dmsc_pos #(
  parameter int unsigned MAX_WIDTH = dmsc_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          advance,
  input  logic [$clog2(MAX_WIDTH):0]    w_eff,
  input  logic [dmsc_pkg::DIM_W-1:0]    h_eff,
  output logic [$clog2(MAX_WIDTH)-1:0]  col,
  output dmsc_pkg::pos_info_t           info
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = CW + 1;
  localparam int unsigned RW = dmsc_pkg::DIM_W;

  logic [CW-1:0] col_r, col_nxt, col_n;
  logic [RW-1:0] row_r, row_nxt, row_n;
  logic [RW-1:0] h_p1;
  logic [WW-1:0] col_inc;
  logic          fend;
  logic          last_px;
  logic          norm_px;

  assign h_p1 = h_eff + RW'(1);

  // Normalize the stored position, then step it
  always_comb begin
    col_n = col_r;
    row_n = row_r;
    if (WW'(col_r) >= w_eff) begin
      col_n = '0;
      row_n = row_r + RW'(1);
    end
    if (row_n > h_p1) begin
      row_n = '0;
      col_n = '0;
    end

    fend    = (col_n == '0) && (row_n == h_p1);
    col_inc = WW'(col_n) + WW'(1);

    if (fend) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (col_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = row_n + RW'(1);
    end else begin
      col_nxt = col_inc[CW-1:0];
      row_nxt = row_n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (advance) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Column 0 closes the row two lines up; other columns emit one line up
  always_comb begin
    last_px = (col_n == '0) && (row_n >= RW'(2));
    norm_px = (col_n != '0) && (row_n != '0) && (row_n <= h_eff);

    info.emit      = last_px | norm_px;
    info.top       = last_px ? (row_n == RW'(2)) : (row_n == RW'(1));
    info.bottom    = last_px ? (row_n == h_p1)   : (row_n == h_eff);
    info.y_odd     = last_px ? row_n[0]          : ~row_n[0];
    info.x_odd     = last_px ? ~w_eff[0]         : ~col_n[0];
    info.x_first   = norm_px && (col_n == CW'(1));
    info.row_end   = last_px;
    info.frame_end = fend;
  end

  assign col = col_n;

endmodule

FILE: src/dmsc_interp.sv
// ----------------------------------------------------------------------------
// dmsc_interp: 3x3 window and bilinear interpolation
// Shifts a new column into the window per request and forms the RGB
// value of the pixel being emitted, with reflect-101 at the borders.
// ----------------------------------------------------------------------------
module dmsc_interp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 shift,
  input  dmsc_pkg::column_t    new_col,
  input  dmsc_pkg::pos_info_t  info,
  output dmsc_pkg::pix_t       red,
  output dmsc_pkg::pix_t       green,
  output dmsc_pkg::pix_t       blue
);

  localparam int unsigned PW = dmsc_pkg::PIX_W;

  dmsc_pkg::column_t col0_r, col1_r, col2_r;
  dmsc_pkg::column_t cc, lc, rc;
  dmsc_pkg::pix_t    cc_up, cc_dn, lc_up, lc_dn, rc_up, rc_dn;
  dmsc_pkg::pix_t    ctr, vpair, hpair, cross_avg, diag_avg;
  logic [PW:0]       vsum, hsum;
  logic [PW+1:0]     csum, dsum;

  // Advance the window by one column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col0_r <= '0;
      col1_r <= '0;
      col2_r <= '0;
    end else if (shift) begin
      col0_r <= col1_r;
      col1_r <= col2_r;
      col2_r <= new_col;
    end
  end

  // Pick center, left and right columns; reflect at row ends
  always_comb begin
    cc = col2_r;
    lc = info.x_first ? new_col : col1_r;
    rc = info.row_end ? col1_r  : new_col;

    cc_up = info.top    ? cc.lower : cc.upper;
    cc_dn = info.bottom ? cc.upper : cc.lower;
    lc_up = info.top    ? lc.lower : lc.upper;
    lc_dn = info.bottom ? lc.upper : lc.lower;
    rc_up = info.top    ? rc.lower : rc.upper;
    rc_dn = info.bottom ? rc.upper : rc.lower;
  end

  // Floor averages of neighbor pairs and quads
  always_comb begin
    ctr  = cc.middle;
    vsum = {1'b0, cc_up} + {1'b0, cc_dn};
    hsum = {1'b0, lc.middle} + {1'b0, rc.middle};
    csum = {1'b0, vsum} + {1'b0, hsum};
    dsum = (PW+2)'(lc_up) + (PW+2)'(rc_up) + (PW+2)'(lc_dn) + (PW+2)'(rc_dn);

    vpair     = vsum[PW:1];
    hpair     = hsum[PW:1];
    cross_avg = csum[PW+1:2];
    diag_avg  = dsum[PW+1:2];
  end

  // Route by site color
  always_comb begin
    case ({info.y_odd, info.x_odd})
      2'b00: begin
        red = ctr;   green = cross_avg; blue = diag_avg;
      end
      2'b01: begin
        red = hpair; green = ctr;       blue = vpair;
      end
      2'b10: begin
        red = vpair; green = ctr;       blue = hpair;
      end
      default: begin
        red = diag_avg; green = cross_avg; blue = ctr;
      end
    endcase
  end

endmodule

FILE: src/bayer_bilinear_demosaic_unit.sv
// ----------------------------------------------------------------------------
// bayer_bilinear_demosaic_unit: streaming RGGB bilinear demosaic
// Turns raw Bayer samples in raster order into RGB pixels.
// ----------------------------------------------------------------------------
// Usage:
//   in_stream  carries one raw 8-bit sample per request, or a drain request
//              that only pushes the pipeline forward (sample taken as zero).
//   out_stream carries one RGB pixel with row_end / frame_end flags.
//   APB port   sets frame_width (0x0) and frame_height (0x4); write only
//              while the stream is idle. Both are clamped to legal values.
//   A frame is W*H samples followed by W+1 drain requests; pixel (r,c) is
//   produced by the request W+1 positions later.
//   Throughput is one request per clock: each request does one read and one
//   write-back of the line memory at its column, and a same-column request
//   in the next cycle takes the written word from a forwarding register.
//   A request's pixel goes from the processing stage to the output register.
//   When out_stream stalls the output register holds the pixel; requests
//   with no pixel still pass, and the next one with a pixel holds in the
//   processing stage and drops in_stream ready.
//   Reset clears position counters and the window; line memory contents are
//   left as they are, and no clearing pass is run.
// ----------------------------------------------------------------------------
module bayer_bilinear_demosaic_unit #(
  parameter int unsigned MAX_WIDTH = dmsc_pkg::MAX_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  dmsc_in_if.sink                          in_stream,
  dmsc_out_if.source                       out_stream,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [dmsc_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [dmsc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [dmsc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = CW + 1;

  logic [WW-1:0]               w_eff;
  logic [dmsc_pkg::DIM_W-1:0]  h_eff;
  logic [CW-1:0]               pos_col;
  dmsc_pkg::pos_info_t         pos_info;

  logic                        in_acc;
  logic                        a_fire;
  dmsc_pkg::pix_t              sample_in;

  logic                        a_valid_r, a_valid_nxt;
  dmsc_pkg::pos_info_t         a_info_r;
  dmsc_pkg::pix_t              a_sample_r;
  logic [CW-1:0]               a_col_r;

  logic                        fwd_r, fwd_nxt;
  dmsc_pkg::line_word_t        fwd_data_r, fwd_data_nxt;

  dmsc_pkg::line_word_t        mem_rd;
  dmsc_pkg::line_word_t        line_cur;
  dmsc_pkg::line_word_t        wr_data;
  dmsc_pkg::column_t           new_col;

  dmsc_pkg::pix_t              px_red, px_green, px_blue;
  logic                        out_valid_r, out_valid_nxt;
  dmsc_pkg::pix_t              out_red_r, out_green_r, out_blue_r;
  logic                        out_row_end_r, out_frame_end_r;

  dmsc_cfg #(.MAX_WIDTH(MAX_WIDTH)) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .w_eff   (w_eff),
    .h_eff   (h_eff)
  );

  dmsc_pos #(.MAX_WIDTH(MAX_WIDTH)) u_pos (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (in_acc),
    .w_eff   (w_eff),
    .h_eff   (h_eff),
    .col     (pos_col),
    .info    (pos_info)
  );

  dmsc_line_mem #(.MAX_WIDTH(MAX_WIDTH)) u_mem (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (pos_col),
    .rd_data (mem_rd),
    .wr_en   (a_fire),
    .wr_addr (a_col_r),
    .wr_data (wr_data)
  );

  dmsc_interp u_interp (
    .clk     (clk),
    .rst_n   (rst_n),
    .shift   (a_fire),
    .new_col (new_col),
    .info    (a_info_r),
    .red     (px_red),
    .green   (px_green),
    .blue    (px_blue)
  );

  // Handshake: the processing stage drains unless its pixel finds no room
  assign a_fire = a_valid_r &&
                  (!a_info_r.emit || !out_valid_r || out_stream.ready);
  assign in_stream.ready = !a_valid_r || a_fire;
  assign in_acc    = in_stream.valid && in_stream.ready;
  assign sample_in = in_stream.drain ? '0 : in_stream.raw_pixel;

  // Line word for the stage: memory or the word just written back
  assign line_cur = fwd_r ? fwd_data_r : mem_rd;
  assign wr_data  = '{upper: line_cur.middle, middle: a_sample_r};
  assign new_col  = '{upper: line_cur.upper, middle: line_cur.middle,
                      lower: a_sample_r};

  // Next state of stage, forwarding and output register
  always_comb begin
    a_valid_nxt  = a_valid_r;
    fwd_nxt      = fwd_r;
    fwd_data_nxt = fwd_data_r;
    if (in_acc) begin
      a_valid_nxt  = 1'b1;
      fwd_nxt      = a_fire && (pos_col == a_col_r);
      fwd_data_nxt = wr_data;
    end else if (a_fire) begin
      a_valid_nxt  = 1'b0;
      fwd_nxt      = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (a_fire && a_info_r.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_stream.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_valid_r   <= a_valid_nxt;
      fwd_r       <= fwd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    fwd_data_r <= fwd_data_nxt;
    if (in_acc) begin
      a_info_r   <= pos_info;
      a_sample_r <= sample_in;
      a_col_r    <= pos_col;
    end
    if (a_fire && a_info_r.emit) begin
      out_red_r       <= px_red;
      out_green_r     <= px_green;
      out_blue_r      <= px_blue;
      out_row_end_r   <= a_info_r.row_end;
      out_frame_end_r <= a_info_r.frame_end;
    end
  end

  assign out_stream.valid     = out_valid_r;
  assign out_stream.red       = out_red_r;
  assign out_stream.green     = out_green_r;
  assign out_stream.blue      = out_blue_r;
  assign out_stream.row_end   = out_row_end_r;
  assign out_stream.frame_end = out_frame_end_r;

  // Forwarded word only exists for a request in the stage
  a_fwd_owned: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> a_valid_r)
    else $error("forwarding flag set with empty stage");

  // An emitting request always lands in the output register
  a_emit_out: assert property (@(posedge clk) disable iff (!rst_n)
    (a_fire && a_info_r.emit) |=> out_valid_r)
    else $error("emitted pixel lost");

  // Last pixel of a frame is also last of its row
  a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_frame_end_r) |-> out_row_end_r)
    else $error("frame_end without row_end");

  // A stalled stage keeps its line word
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && !a_fire) |=> ($stable(mem_rd) && $stable(a_col_r)))
    else $error("line word changed under a stalled request");

endmodule
